[hw/rtl/assert_macros.svh]
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define MMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define MMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/mma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

    localparam int MAX_DIM = 16;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int SIZE_W  = $clog2(MAX_DIM + 1);

    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + DIM_W + 1;
    localparam int CMP_W     = SIZE_W + IDX_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd2;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0]  OUT_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [VAL_W-1:0]  OUT_MIN  = 32'sh80000000;
    localparam logic signed [ACC_W-1:0]  ACC_MAX  = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = ACC_W'(OUT_MIN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             wr_left;
        logic             wr_right;
        logic             start;
        logic             rd_en;
        logic [DIM_W-1:0] rd_k;
        logic             emit;
    } cmd_t;

    typedef struct packed {
        logic pipe_empty;
        logic out_busy;
    } status_t;

    function automatic logic signed [ELEM_W-1:0] sat_elem(input logic signed [VAL_W-1:0] v);
        logic signed [ELEM_W-1:0] r;
        if (v > VAL_W'(ELEM_MAX))
            r = ELEM_MAX;
        else if (v < VAL_W'(ELEM_MIN))
            r = ELEM_MIN;
        else
            r = v[ELEM_W-1:0];
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [SIZE_W-1:0] s;
        if (int'(r) > MAX_DIM)
            s = SIZE_W'(MAX_DIM);
        else
            s = SIZE_W'(r);
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mma_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mma_item_if;
    logic                                 valid;
    logic                                 ready;
    logic [mma_pkg::OP_W-1:0]             opcode;
    logic [mma_pkg::IDX_W-1:0]            row;
    logic [mma_pkg::IDX_W-1:0]            col;
    logic signed [mma_pkg::VAL_W-1:0]     value;

    modport source (output valid, output opcode, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input opcode, input row, input col, input value,
                    output ready);
endinterface

interface mma_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [mma_pkg::IDX_W-1:0]            out_row;
    logic [mma_pkg::IDX_W-1:0]            out_col;
    logic signed [mma_pkg::VAL_W-1:0]     out_value;
    logic                                 saturated;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output saturated, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/mma_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mma_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mma_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [mma_pkg::OP_W-1:0]          item_opcode,
    input  wire logic [mma_pkg::IDX_W-1:0]         item_row,
    input  wire logic [mma_pkg::IDX_W-1:0]         item_col,
    input  wire mma_pkg::status_t                  status,
    output mma_pkg::cmd_t                          cmd
);

    mma_pkg::state_t state_reg, state_next;
    logic [mma_pkg::CFG_W-1:0]  rows_reg, cols_reg, inner_reg;
    logic [mma_pkg::DIM_W-1:0]  k_reg, k_next;
    logic [mma_pkg::SIZE_W-1:0] nr, nc, nk;
    logic [mma_pkg::CMP_W-1:0]  row_x, col_x, nr_x, nc_x, nk_x;
    logic                       accept, last_k;
    logic                       left_ok, right_ok, comp_ok;

    assign nr    = mma_pkg::eff_size(rows_reg);
    assign nc    = mma_pkg::eff_size(cols_reg);
    assign nk    = mma_pkg::eff_size(inner_reg);
    assign row_x = mma_pkg::CMP_W'(item_row);
    assign col_x = mma_pkg::CMP_W'(item_col);
    assign nr_x  = mma_pkg::CMP_W'(nr);
    assign nc_x  = mma_pkg::CMP_W'(nc);
    assign nk_x  = mma_pkg::CMP_W'(nk);

    assign item_ready = (state_reg == mma_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;

    assign left_ok  = (item_opcode == mma_pkg::OP_LOAD_LEFT)  && (row_x < nr_x) && (col_x < nk_x);
    assign right_ok = (item_opcode == mma_pkg::OP_LOAD_RIGHT) && (row_x < nk_x) && (col_x < nc_x);
    assign comp_ok  = (item_opcode == mma_pkg::OP_COMPUTE)    && (row_x < nr_x) && (col_x < nc_x);
    assign last_k   = (mma_pkg::SIZE_W'(k_reg) + mma_pkg::SIZE_W'(1)) == nk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= mma_pkg::CFG_RESET;
            cols_reg  <= mma_pkg::CFG_RESET;
            inner_reg <= mma_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mma_pkg::REG_ROWS:  rows_reg  <= cfg_wdata;
                mma_pkg::REG_COLS:  cols_reg  <= cfg_wdata;
                mma_pkg::REG_INNER: inner_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mma_pkg::ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                k_next = '0;
                if (accept && comp_ok)
                begin
                    if (nk == '0)
                        state_next = mma_pkg::ST_FINISH;
                    else
                        state_next = mma_pkg::ST_RUN;
                end
            end
            mma_pkg::ST_RUN:
            begin
                k_next = k_reg + mma_pkg::DIM_W'(1);
                if (last_k)
                    state_next = mma_pkg::ST_DRAIN;
            end
            mma_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty)
                    state_next = mma_pkg::ST_FINISH;
            end
            mma_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                    state_next = mma_pkg::ST_IDLE;
            end
            default:
                state_next = mma_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.rd_k = k_reg;
        case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                cmd.wr_left  = accept && left_ok;
                cmd.wr_right = accept && right_ok;
                cmd.start    = accept && comp_ok;
            end
            mma_pkg::ST_RUN:
                cmd.rd_en = 1'b1;
            mma_pkg::ST_DRAIN: ;
            mma_pkg::ST_FINISH:
                cmd.emit = !status.out_busy;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/mma_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module mma_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mma_pkg::cmd_t                     cmd,
    output mma_pkg::status_t                       status,
    input  wire logic [mma_pkg::IDX_W-1:0]         item_row,
    input  wire logic [mma_pkg::IDX_W-1:0]         item_col,
    input  wire logic signed [mma_pkg::VAL_W-1:0]  item_value,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [mma_pkg::IDX_W-1:0]              out_row,
    output logic [mma_pkg::IDX_W-1:0]              out_col,
    output logic signed [mma_pkg::VAL_W-1:0]       out_value,
    output logic                                   out_saturated
);

    logic signed [mma_pkg::ELEM_W-1:0] left_mem  [mma_pkg::DEPTH];
    logic signed [mma_pkg::ELEM_W-1:0] right_mem [mma_pkg::DEPTH];

    logic [mma_pkg::ADDR_W-1:0]        wr_addr, left_rd_addr, right_rd_addr;
    logic signed [mma_pkg::ELEM_W-1:0] wr_data;
    logic [mma_pkg::IDX_W-1:0]         row_reg, col_reg;
    logic signed [mma_pkg::ELEM_W-1:0] left_rd_reg, right_rd_reg;
    logic signed [mma_pkg::PROD_W-1:0] prod_reg;
    logic signed [mma_pkg::ACC_W-1:0]  acc_reg;
    logic                              rd_vld_reg, prod_vld_reg, out_vld_reg;
    logic [mma_pkg::IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [mma_pkg::VAL_W-1:0]  out_value_reg, sat_value;
    logic                              out_sat_reg, sat_flag;

    assign wr_addr       = {mma_pkg::DIM_W'(item_row), mma_pkg::DIM_W'(item_col)};
    assign wr_data       = mma_pkg::sat_elem(item_value);
    assign left_rd_addr  = {mma_pkg::DIM_W'(row_reg), cmd.rd_k};
    assign right_rd_addr = {cmd.rd_k, mma_pkg::DIM_W'(col_reg)};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_left)
            left_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            left_rd_reg <= left_mem[left_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_right)
            right_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            right_rd_reg <= right_mem[right_rd_addr];
    end

    // multiply and accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= left_rd_reg * right_rd_reg;
        if (cmd.start)
        begin
            row_reg <= item_row;
            col_reg <= item_col;
            acc_reg <= mma_pkg::ACC_W'(item_value);
        end
        else if (prod_vld_reg)
            acc_reg <= acc_reg + mma_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.rd_en;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_comb
    begin
        sat_flag  = 1'b0;
        sat_value = acc_reg[mma_pkg::VAL_W-1:0];
        if (acc_reg > mma_pkg::ACC_MAX)
        begin
            sat_flag  = 1'b1;
            sat_value = mma_pkg::OUT_MAX;
        end
        else if (acc_reg < mma_pkg::ACC_MIN)
        begin
            sat_flag  = 1'b1;
            sat_value = mma_pkg::OUT_MIN;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.emit)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_value_reg <= sat_value;
            out_sat_reg   <= sat_flag;
        end
    end

    assign status.pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign status.out_busy   = out_vld_reg && !out_ready;

    assign out_valid     = out_vld_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign out_value     = out_value_reg;
    assign out_saturated = out_sat_reg;

endmodule

`default_nettype wire

[hw/rtl/matrix_multiply_accumulate_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   role     transaction
// -------   ------   ------------------------------------------------
// item      sink     opcode, row, col, value (load or compute)
// result    source   out_row, out_col, out_value, saturated
// cfg       write    cfg_wr_en, cfg_index, cfg_wdata (sizes in use)
//
// a load is written into its store at acceptance if in range and does not stall the input
// a compute: n reads, drain, finish, n = inner_in_use capped at 16 (finish alone if n is 0),
// on one shared multiply-accumulate unit behind a registered store read and a product register
// the finished result sits in an output register; loads go on while it waits
// a compute holds in its last step while the output register is still full
// reset clears control and sizes (16 each); the element stores are not cleared

module matrix_multiply_accumulate_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mma_pkg::CFG_W-1:0]     cfg_wdata,
    mma_item_if.sink                           item,
    mma_result_if.source                       result
);

    mma_pkg::cmd_t    cmd;
    mma_pkg::status_t status;

    mma_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item.valid),
        .item_ready  (item.ready),
        .item_opcode (item.opcode),
        .item_row    (item.row),
        .item_col    (item.col),
        .status      (status),
        .cmd         (cmd)
    );

    mma_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .item_row      (item.row),
        .item_col      (item.col),
        .item_value    (item.value),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .out_row       (result.out_row),
        .out_col       (result.out_col),
        .out_value     (result.out_value),
        .out_saturated (result.saturated)
    );

endmodule

`default_nettype wire

[hw/rtl/mma_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mma_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             item_valid,
    input wire logic                             item_ready,
    input wire logic [mma_pkg::OP_W-1:0]         item_opcode,
    input wire logic                             result_valid,
    input wire logic                             result_ready,
    input wire logic [mma_pkg::IDX_W-1:0]        result_out_row,
    input wire logic signed [mma_pkg::VAL_W-1:0] result_out_value,
    input wire logic                             result_saturated
);

    `MMA_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !result_valid, "result during reset")

    `MMA_ASSERT(a_result_held, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(result_out_value) && $stable(result_out_row), "stalled result changed")

    `MMA_ASSERT(a_sat_at_limit, clk, rst_n, result_valid && result_saturated |-> result_out_value == mma_pkg::OUT_MAX || result_out_value == mma_pkg::OUT_MIN, "saturated result not at a limit")

    `MMA_ASSERT(a_load_no_stall, clk, rst_n, item_valid && item_ready && item_opcode != mma_pkg::OP_COMPUTE |=> item_ready, "non-compute transaction stalled the input")

endmodule

bind matrix_multiply_accumulate_unit mma_checker u_mma_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_opcode      (item.opcode),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_out_row   (result.out_row),
    .result_out_value (result.out_value),
    .result_saturated (result.saturated)
);

`default_nettype wire
